[hw/rtl/retransmit_tracker_with_dedup_top_assert.svh]
// assertion macros shared by the rtl
`ifndef RETRANSMIT_TRACKER_WITH_DEDUP_TOP_ASSERT_SVH
`define RETRANSMIT_TRACKER_WITH_DEDUP_TOP_ASSERT_SVH

// same-cycle implication
`define RTDD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtdd assertion failed");

// next-cycle implication
`define RTDD_ASSERT_NX(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtdd assertion failed");

`endif

[hw/rtl/rtdd_pkg.sv]
`default_nettype none
package rtdd_pkg;

  localparam int QDepth  = 8;
  localparam int HDepth  = 16;
  localparam int QIdxW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);
  localparam int HIdxW   = $clog2(HDepth);

  localparam logic [1:0] ReqEnqueue = 2'd0;
  localparam logic [1:0] ReqNotice  = 2'd1;
  localparam logic [1:0] ReqTick    = 2'd2;
  localparam logic [1:0] ReqRecv    = 2'd3;

  localparam logic [1:0] RegBridge  = 2'd0;
  localparam logic [1:0] RegSilence = 2'd1;
  localparam logic [1:0] RegRetry   = 2'd2;
  localparam logic [1:0] RegBcast   = 2'd3;

  localparam logic [3:0] EvQueued  = 4'd0;
  localparam logic [3:0] EvFull    = 4'd1;
  localparam logic [3:0] EvSent    = 4'd2;
  localparam logic [3:0] EvBcast   = 4'd3;
  localparam logic [3:0] EvAwait   = 4'd4;
  localparam logic [3:0] EvError   = 4'd5;
  localparam logic [3:0] EvDropped = 4'd6;
  localparam logic [3:0] EvResend  = 4'd7;
  localparam logic [3:0] EvDup     = 4'd8;
  localparam logic [3:0] EvMatched = 4'd9;
  localparam logic [3:0] EvBridge  = 4'd10;
  localparam logic [3:0] EvIgnored = 4'd11;

  typedef struct packed {
    logic        used;
    logic [15:0] rid;
    logic [15:0] fid;
    logic [7:0]  kind;
    logic        wait_send;
    logic        await_rsp;
    logic        no_reply;
    logic [7:0]  retries;
    logic [7:0]  silence;
  } entry_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] rid;
    logic [7:0]  rk;
    logic [7:0]  retries;
    logic        last;
  } evt_t;

  typedef struct packed {
    logic   shift;
    entry_t upd;
    entry_t nbr;
  } cell_ctl_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] x);
    sat_inc = (x == 8'hFF) ? x : x + 8'd1;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/rtdd_if.sv]
`default_nettype none
interface rtdd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] req_ident;
  logic [15:0] frame_id;
  logic [7:0]  request_kind;
  logic        no_reply_expected;
  logic        radio_accepts;
  logic [7:0]  app_id;
  logic [7:0]  nspace_id;
  modport source (output valid, req_type, req_ident, frame_id, request_kind,
                  no_reply_expected, radio_accepts, app_id, nspace_id, input ready);
  modport sink (input valid, req_type, req_ident, frame_id, request_kind,
                no_reply_expected, radio_accepts, app_id, nspace_id, output ready);
endinterface

interface rtdd_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [15:0] event_req_ident;
  logic [7:0]  event_request_kind;
  logic [7:0]  event_retries;
  logic        last_event;
  modport source (output valid, event_kind, event_req_ident, event_request_kind,
                  event_retries, last_event, input ready);
  modport sink (input valid, event_kind, event_req_ident, event_request_kind,
                event_retries, last_event, output ready);
endinterface

interface rtdd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/retransmit_tracker_with_dedup_top.sv]
`default_nettype none
// channel  | dir | payload
// req_i    | in  | req_type, req_ident, frame_id, request_kind, flags, app/namespace ids
// evt_o    | out | event_kind, event_req_ident, event_request_kind, event_retries, last_event
// cfg_i    | in  | index, data (always ready)
// an item is taken in the idle state; enqueue, notice and receive then pass through the execute and finish states
// a tick steps through at most 8 entries in index order (a removal stays on its index), then ends
//   and passes to the finish state
// compaction shifts every cell from the removed index upward at once
// a result waits in a holding register so last_event can be set; full output stalls the walk
// reset clears the used bits, the id history, the config and state registers; no clearing pass
module retransmit_tracker_with_dedup_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  rtdd_req_if.sink   req_i,
  rtdd_evt_if.source evt_o,
  rtdd_cfg_if.sink   cfg_i
);
  import rtdd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [QCntW-1:0] ti_q, ti_d;

  logic       bridge_q;
  logic [7:0] sil_lim_q, ret_lim_q, bmask_q;

  logic [1:0]  typ_q;
  logic [15:0] rid_q, fid_q;
  logic [7:0]  kind_q, app_q, ns_q;
  logic        nr_q, acc_q;

  logic pend_valid_q;
  evt_t pend_q, out_q;
  logic out_valid_q;

  entry_t    ent [QDepth];
  entry_t    ent_mod [QDepth];
  cell_ctl_t ctl [QDepth];

  logic [QDepth-1:0] used_v;
  logic [QIdxW-1:0]  free_idx, m_idx, r_idx, cur_idx;
  logic              full, m_found, r_found;
  logic [15:0]       key_rid;
  entry_t            cur, mval;
  logic [7:0]        sil_n;
  logic              tick_end, hit;

  logic       step_ev, mod_en, rm_en, hist_wr, fire, out_free, load_out;
  logic [QIdxW-1:0] mod_idx, rm_idx;
  evt_t       ev;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bridge_q  <= 1'b0;
      sil_lim_q <= 8'd5;
      ret_lim_q <= 8'd3;
      bmask_q   <= 8'd1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegBridge:  bridge_q  <= cfg_i.data[0];
        RegSilence: sil_lim_q <= cfg_i.data;
        RegRetry:   ret_lim_q <= cfg_i.data;
        RegBcast:   bmask_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < QDepth; k++) used_v[k] = ent[k].used;
    full     = &used_v;
    free_idx = '0;
    for (int k = QDepth - 1; k >= 0; k--) begin
      if (!used_v[k]) free_idx = QIdxW'(k);
    end
    m_found = 1'b0;
    m_idx   = '0;
    for (int k = QDepth - 1; k >= 0; k--) begin
      if (used_v[k] && ent[k].fid == fid_q) begin
        m_found = 1'b1;
        m_idx   = QIdxW'(k);
      end
    end
    cur_idx  = ti_q[QIdxW-1:0];
    cur      = ent[cur_idx];
    tick_end = (ti_q == QCntW'(QDepth)) || !cur.used;
    if (state_q == S_TICK) key_rid = cur.rid;
    else if (typ_q == ReqNotice) key_rid = ent[m_idx].rid;
    else key_rid = rid_q;
    r_found = 1'b0;
    r_idx   = '0;
    for (int k = QDepth - 1; k >= 0; k--) begin
      if (used_v[k] && ent[k].rid == key_rid) begin
        r_found = 1'b1;
        r_idx   = QIdxW'(k);
      end
    end
    sil_n = sat_inc(cur.silence);
  end

  rtdd_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (hist_wr),
    .id_i   ({rid_q, app_q, ns_q}),
    .hit_o  (hit)
  );

  always_comb begin
    step_ev = 1'b0;
    mod_en  = 1'b0;
    rm_en   = 1'b0;
    mod_idx = '0;
    rm_idx  = r_idx;
    mval    = cur;
    ev      = '0;
    state_d = state_q;
    ti_d    = ti_q;
    hist_wr = 1'b0;
    out_free = !out_valid_q || evt_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = (req_i.req_type == ReqTick) ? S_TICK : S_EXEC;
          ti_d    = '0;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        unique case (typ_q)
          ReqEnqueue: begin
            step_ev = 1'b1;
            if (full) begin
              ev = '{EvFull, rid_q, kind_q, 8'd0, 1'b0};
            end else begin
              ev      = '{EvQueued, rid_q, kind_q, 8'd0, 1'b0};
              mod_en  = 1'b1;
              mod_idx = free_idx;
              mval    = '{1'b1, rid_q, fid_q, kind_q, 1'b1, 1'b0, nr_q, 8'd0, 8'd0};
            end
          end
          ReqNotice: begin
            if (m_found) begin
              step_ev = 1'b1;
              if ((ent[m_idx].kind & bmask_q) != 8'd0) begin
                rm_en = 1'b1;
                ev = '{EvBcast, ent[r_idx].rid, ent[r_idx].kind, ent[r_idx].retries, 1'b0};
              end else begin
                mod_en  = 1'b1;
                mod_idx = m_idx;
                mval    = ent[m_idx];
                mval.wait_send = 1'b0;
                mval.await_rsp = 1'b1;
                ev = '{EvAwait, ent[m_idx].rid, ent[m_idx].kind, ent[m_idx].retries, 1'b0};
              end
            end
          end
          ReqTick: ;
          ReqRecv: begin
            step_ev = 1'b1;
            if (hit) begin
              ev = '{EvDup, rid_q, kind_q, 8'd0, 1'b0};
            end else begin
              hist_wr = 1'b1;
              if (r_found) begin
                rm_en = 1'b1;
                ev = '{EvMatched, rid_q, kind_q, ent[r_idx].retries, 1'b0};
              end else if (bridge_q) begin
                ev = '{EvBridge, rid_q, kind_q, 8'd0, 1'b0};
              end else begin
                ev = '{EvIgnored, rid_q, kind_q, 8'd0, 1'b0};
              end
            end
          end
          default: ;
        endcase
      end
      S_TICK: begin
        mod_idx = cur_idx;
        if (tick_end) begin
          state_d = S_FIN;
        end else begin
          ti_d = ti_q + 1'b1;
          if (cur.wait_send) begin
            if (acc_q) begin
              step_ev = 1'b1;
              mod_en  = 1'b1;
              mval.wait_send = 1'b0;
              ev = '{EvSent, cur.rid, cur.kind, cur.retries, 1'b0};
            end
          end else if (cur.await_rsp) begin
            mod_en = 1'b1;
            mval.silence = sil_n;
            if (cur.no_reply || (sil_n > sil_lim_q && cur.retries > ret_lim_q)) begin
              step_ev = 1'b1;
              rm_en   = 1'b1;
              ti_d    = ti_q;
              ev = '{(ent[r_idx].no_reply ? EvDropped : EvError), ent[r_idx].rid,
                     ent[r_idx].kind, ent[r_idx].retries, 1'b0};
            end else if (sil_n > sil_lim_q) begin
              step_ev = 1'b1;
              mval.await_rsp = 1'b0;
              mval.wait_send = 1'b1;
              mval.retries   = sat_inc(cur.retries);
              mval.silence   = 8'd0;
              ev = '{EvResend, cur.rid, cur.kind, sat_inc(cur.retries), 1'b0};
            end
          end
        end
      end
      S_FIN: begin
        if (!pend_valid_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    fire = !step_ev || !pend_valid_q || out_free;
    if (!fire) begin
      mod_en  = 1'b0;
      rm_en   = 1'b0;
      hist_wr = 1'b0;
      state_d = state_q;
      ti_d    = ti_q;
    end
    load_out = (step_ev && fire && pend_valid_q) ||
               (state_q == S_FIN && pend_valid_q && out_free);
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    for (int k = 0; k < QDepth; k++) begin
      ent_mod[k] = (mod_en && QIdxW'(k) == mod_idx) ? mval : ent[k];
    end
  end

  for (genvar j = 0; j < QDepth; j++) begin : g_cell
    always_comb begin
      ctl[j].shift = rm_en && (rm_idx <= QIdxW'(j));
      ctl[j].upd   = ent_mod[j];
      ctl[j].nbr   = (j == QDepth - 1) ? '0 : ent_mod[(j + 1) % QDepth];
    end
    rtdd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[j]),
      .ent_o  (ent[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      typ_q  <= req_i.req_type;
      rid_q  <= req_i.req_ident;
      fid_q  <= req_i.frame_id;
      kind_q <= req_i.request_kind;
      nr_q   <= req_i.no_reply_expected;
      acc_q  <= req_i.radio_accepts;
      app_q  <= req_i.app_id;
      ns_q   <= req_i.nspace_id;
    end
    if (step_ev && fire) pend_q <= ev;
    if (load_out) begin
      out_q <= '{pend_q.kind, pend_q.rid, pend_q.rk, pend_q.retries, (state_q == S_FIN)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ti_q         <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ti_q    <= ti_d;
      if (step_ev && fire) pend_valid_q <= 1'b1;
      else if (state_q == S_FIN && out_free) pend_valid_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
      else if (evt_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign evt_o.valid              = out_valid_q;
  assign evt_o.event_kind         = out_q.kind;
  assign evt_o.event_req_ident    = out_q.rid;
  assign evt_o.event_request_kind = out_q.rk;
  assign evt_o.event_retries      = out_q.retries;
  assign evt_o.last_event         = out_q.last;

  `include "retransmit_tracker_with_dedup_top_assert.svh"

  `RTDD_ASSERT(a_idle_no_pend, state_q == S_IDLE, !pend_valid_q)
  `RTDD_ASSERT(a_used_prefix, 1'b1, (used_v & (used_v + 1'b1)) == '0)
  `RTDD_ASSERT(a_tick_range, state_q == S_TICK, ti_q <= QCntW'(QDepth))
  `RTDD_ASSERT_NX(a_fin_flush, state_q == S_FIN && pend_valid_q && out_free,
                  out_valid_q && out_q.last)
endmodule
`default_nettype wire

[hw/rtl/rtdd_cell.sv]
`default_nettype none
module rtdd_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rtdd_pkg::cell_ctl_t ctl_i,
  output rtdd_pkg::entry_t        ent_o
);
  import rtdd_pkg::*;

  entry_t d;
  logic   used_q;
  entry_t data_q;

  assign d = ctl_i.shift ? ctl_i.nbr : ctl_i.upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= d.used;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= d;
  end

  always_comb begin
    ent_o      = data_q;
    ent_o.used = used_q;
  end
endmodule
`default_nettype wire

[hw/rtl/rtdd_hist.sv]
`default_nettype none
module rtdd_hist (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_i,
  input  wire logic [31:0] id_i,
  output logic             hit_o
);
  import rtdd_pkg::*;

  logic [31:0]      ids_q [HDepth];
  logic [HIdxW-1:0] ptr_q;

  always_comb begin
    hit_o = 1'b0;
    for (int k = 0; k < HDepth; k++) begin
      if (ids_q[k] == id_i) hit_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HDepth; k++) ids_q[k] <= '0;
      ptr_q <= '0;
    end else if (wr_i) begin
      ids_q[ptr_q] <= id_i;
      ptr_q <= (ptr_q == HIdxW'(HDepth - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  `include "retransmit_tracker_with_dedup_top_assert.svh"

  `RTDD_ASSERT(a_ptr_range, 1'b1, ptr_q <= HIdxW'(HDepth - 1))
  `RTDD_ASSERT_NX(a_ptr_moves, wr_i, ptr_q != $past(ptr_q) || HDepth == 1)
  `RTDD_ASSERT_NX(a_written_hits, wr_i, ids_q[$past(ptr_q)] == $past(id_i))
endmodule
`default_nettype wire
